>>> rtl/loewner_flow_side_classifier_core_defines.svh
// Assertion macros for the Loewner flow side classifier.
`ifndef LOEWNER_FLOW_SIDE_CLASSIFIER_CORE_DEFINES_SVH
`define LOEWNER_FLOW_SIDE_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled in reset.
`define LFSC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and disabled in reset.
`define LFSC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/lfsc_pkg.sv
// Shared constants, codes and types of the Loewner flow side classifier.
package lfsc_pkg;
	localparam int MAX_SAMPLES_DEF = 131072;
	localparam int VALUE_BITS_DEF  = 48;

	localparam int SAMPLE_INDEX_W = 17;
	localparam int COUNT_W        = 18;
	localparam int STEP_W         = 32;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 32;
	localparam int HALF_W         = 32;
	localparam int OPER_W         = 64;
	localparam int ACC_W          = 128;
	localparam int DEN_W          = 64;
	localparam int NUM_W          = 97;
	localparam int MSTEP_W        = 4;

	localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RST = 18'd90000;
	localparam logic [STEP_W-1:0]  STEP_SIZE_RST    = 32'd47722;

	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE    = 2'd1;

	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;
	localparam logic SIDE_LEFT  = 1'b0;
	localparam logic SIDE_RIGHT = 1'b1;

	// Partial-product schedule of the shared multiplier.
	localparam logic [MSTEP_W-1:0] MS_SQ_FIRST = 4'd0;
	localparam logic [MSTEP_W-1:0] MS_SQ_LAST  = 4'd7;
	localparam logic [MSTEP_W-1:0] MS_RE_FIRST = 4'd8;
	localparam logic [MSTEP_W-1:0] MS_RE_LAST  = 4'd9;
	localparam logic [MSTEP_W-1:0] MS_IM_LAST  = 4'd11;
	localparam logic [MSTEP_W-1:0] MS_RE_DONE  = 4'd10;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_MUL,
		ST_ACC,
		ST_DEN,
		ST_DIVLD,
		ST_DIV,
		ST_UPDATE,
		ST_DONE
	} state_t;
endpackage

>>> rtl/loewner_flow_side_classifier_core.sv
// Loewner flow side classifier: sample table, flow sequencer and shared multiply/divide unit.
//
// Usage. Input channel (in_valid/in_stall) carries either a sample load
// (req_type 0: sample_index, drive_value) or a point query (req_type 1:
// point_re, point_im). Loads go from the last index downward and finish in
// the cycle of their transfer; they give no result. A query gives one side
// bit on the output channel (out_valid/out_stall).
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
// taken; index 0 is sample_count, index 1 is step_size, others are dropped.
// A query holds in_stall high while it runs, so the block takes no new
// request before the last one is through. Each flow step is one table read,
// one check, eight multiply/accumulate pairs for |z-W|^2, one denominator
// clamp, then per part two multiply/accumulate pairs, one divider load, the
// radix-2 divider for a 97-bit quotient and one update, on the single 32x32
// multiplier and the bit-serial divider. A query runs at most one flow step
// per counted sample, fewer on an early exit.
// Reset clears the running extremes and the control state and restores the
// register defaults; the sample table holds nothing until loaded.
// A result waiting under out_stall stays in the output register; the block
// takes the next transfer once it has moved the result there.
`include "loewner_flow_side_classifier_core_defines.svh"

module loewner_flow_side_classifier_core #(
	parameter int MAX_SAMPLES = lfsc_pkg::MAX_SAMPLES_DEF,
	parameter int VALUE_BITS  = lfsc_pkg::VALUE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   req_type,
	input  logic [lfsc_pkg::SAMPLE_INDEX_W-1:0]    sample_index,
	input  logic signed [VALUE_BITS-1:0]           drive_value,
	input  logic signed [VALUE_BITS-1:0]           point_re,
	input  logic signed [VALUE_BITS-1:0]           point_im,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   side,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [lfsc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [lfsc_pkg::CFG_DATA_W-1:0]        cfg_data
);
	localparam int IW  = $clog2(MAX_SAMPLES);
	localparam int CW  = $clog2(MAX_SAMPLES + 1);
	localparam int MW  = 3 * VALUE_BITS;
	localparam int DCW = $clog2(lfsc_pkg::NUM_W + 1);
	localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

	function automatic logic signed [VALUE_BITS-1:0] sat_fit(
		input logic signed [VALUE_BITS:0] x);
		logic signed [VALUE_BITS-1:0] r;
		if (x[VALUE_BITS] != x[VALUE_BITS-1]) begin
			r = x[VALUE_BITS] ? VMIN : VMAX;
		end else begin
			r = x[VALUE_BITS-1:0];
		end
		return r;
	endfunction

	lfsc_pkg::state_t state_q, state_d;

	logic [lfsc_pkg::COUNT_W-1:0] sample_count_q;
	logic [lfsc_pkg::STEP_W-1:0]  step_size_q;
	logic signed [VALUE_BITS-1:0] run_min_q, run_max_q;
	logic [CW-1:0]                cnt_eff;

	logic [MW-1:0] mem [MAX_SAMPLES];
	logic [MW-1:0] rd_q;
	logic [IW-1:0] rd_addr;

	logic signed [VALUE_BITS-1:0] re_q, im_q, w_q;
	logic [VALUE_BITS-1:0]        are_q, aim_q;
	logic                         dre_neg_q;
	logic [CW-1:0]                k_q;
	logic                         res_q;
	logic                         out_valid_q, side_q;

	logic [lfsc_pkg::MSTEP_W-1:0]  mstep_q;
	logic [2*lfsc_pkg::HALF_W-1:0] prod_q;
	logic [1:0]                    sh_q;
	logic [lfsc_pkg::ACC_W-1:0]    acc_q;
	logic [lfsc_pkg::DEN_W-1:0]    den_q;
	logic [lfsc_pkg::NUM_W-1:0]    num_q, quo_q;
	logic [lfsc_pkg::DEN_W-1:0]    rem_q;
	logic [DCW-1:0]                dcnt_q;

	// Combinational datapath signals.
	logic                         in_xfer, wr_en, ld_restart;
	logic signed [VALUE_BITS-1:0] new_min, new_max;
	logic signed [VALUE_BITS-1:0] w_rd, smin_rd, smax_rd;
	logic                         chk_exit, chk_side;
	logic signed [VALUE_BITS-1:0] dre;
	logic [VALUE_BITS-1:0]        are_d;
	logic [lfsc_pkg::OPER_W-1:0]  are_w, aim_w;
	logic [lfsc_pkg::HALF_W-1:0]  mul_a, mul_b;
	logic [1:0]                   mul_sh;
	logic [lfsc_pkg::DEN_W:0]     div_r2;
	logic                         div_ge;
	logic [VALUE_BITS-1:0]        qv;
	logic signed [VALUE_BITS:0]   re_sum, im_sum;
	logic                         last_step, out_load;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != lfsc_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign side      = side_q;
	assign in_xfer   = in_valid && !in_stall;

	always_comb begin
		if (sample_count_q == '0) begin
			cnt_eff = CW'(1);
		end else if (32'(sample_count_q) > 32'(MAX_SAMPLES)) begin
			cnt_eff = CW'(MAX_SAMPLES);
		end else begin
			cnt_eff = CW'(sample_count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= lfsc_pkg::SAMPLE_COUNT_RST;
			step_size_q    <= lfsc_pkg::STEP_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lfsc_pkg::CFG_SAMPLE_COUNT: sample_count_q <= cfg_data[lfsc_pkg::COUNT_W-1:0];
				lfsc_pkg::CFG_STEP_SIZE:    step_size_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sample load: restart or extend the running extremes.
	assign ld_restart = 32'(sample_index) >= (32'(cnt_eff) - 32'd1);
	assign wr_en = in_xfer && (req_type == lfsc_pkg::REQ_LOAD)
		&& (32'(sample_index) < 32'(MAX_SAMPLES));
	assign new_min = (ld_restart || drive_value < run_min_q) ? drive_value : run_min_q;
	assign new_max = (ld_restart || drive_value > run_max_q) ? drive_value : run_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q <= '0;
			run_max_q <= '0;
		end else if (wr_en) begin
			run_min_q <= new_min;
			run_max_q <= new_max;
		end
	end

	assign rd_addr = k_q[IW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[IW'(sample_index)] <= {drive_value, new_min, new_max};
		end
		rd_q <= mem[rd_addr];
	end

	assign w_rd    = rd_q[MW-1 -: VALUE_BITS];
	assign smin_rd = rd_q[2*VALUE_BITS-1 -: VALUE_BITS];
	assign smax_rd = rd_q[VALUE_BITS-1:0];

	// Early exits of one flow step.
	always_comb begin
		chk_exit = 1'b1;
		chk_side = lfsc_pkg::SIDE_LEFT;
		if (im_q <= 0) begin
			chk_side = (re_q < w_rd) ? lfsc_pkg::SIDE_LEFT : lfsc_pkg::SIDE_RIGHT;
		end else if (re_q < smin_rd) begin
			chk_side = lfsc_pkg::SIDE_LEFT;
		end else if (re_q > smax_rd) begin
			chk_side = lfsc_pkg::SIDE_RIGHT;
		end else begin
			chk_exit = 1'b0;
		end
	end

	assign dre   = sat_fit({re_q[VALUE_BITS-1], re_q} - {w_rd[VALUE_BITS-1], w_rd});
	assign are_d = dre[VALUE_BITS-1] ? (~dre + 1'b1) : dre;
	assign are_w = lfsc_pkg::OPER_W'(are_q);
	assign aim_w = lfsc_pkg::OPER_W'(aim_q);

	// Partial-product schedule: squares, then dt*|dre|, then dt*|im|.
	always_comb begin
		mul_a  = are_w[31:0];
		mul_b  = are_w[31:0];
		mul_sh = 2'd0;
		case (mstep_q)
			4'd0: begin mul_a = are_w[31:0];  mul_b = are_w[31:0];  mul_sh = 2'd0; end
			4'd1: begin mul_a = are_w[31:0];  mul_b = are_w[63:32]; mul_sh = 2'd1; end
			4'd2: begin mul_a = are_w[63:32]; mul_b = are_w[31:0];  mul_sh = 2'd1; end
			4'd3: begin mul_a = are_w[63:32]; mul_b = are_w[63:32]; mul_sh = 2'd2; end
			4'd4: begin mul_a = aim_w[31:0];  mul_b = aim_w[31:0];  mul_sh = 2'd0; end
			4'd5: begin mul_a = aim_w[31:0];  mul_b = aim_w[63:32]; mul_sh = 2'd1; end
			4'd6: begin mul_a = aim_w[63:32]; mul_b = aim_w[31:0];  mul_sh = 2'd1; end
			4'd7: begin mul_a = aim_w[63:32]; mul_b = aim_w[63:32]; mul_sh = 2'd2; end
			4'd8: begin mul_a = step_size_q;  mul_b = are_w[31:0];  mul_sh = 2'd0; end
			4'd9: begin mul_a = step_size_q;  mul_b = are_w[63:32]; mul_sh = 2'd1; end
			4'd10: begin mul_a = step_size_q; mul_b = aim_w[31:0];  mul_sh = 2'd0; end
			4'd11: begin mul_a = step_size_q; mul_b = aim_w[63:32]; mul_sh = 2'd1; end
			default: ;
		endcase
	end

	assign div_r2 = {rem_q, num_q[lfsc_pkg::NUM_W-1]};
	assign div_ge = div_r2 >= {1'b0, den_q};

	assign qv = (|quo_q[lfsc_pkg::NUM_W-1:VALUE_BITS-1]) ? VMAX
		: {1'b0, quo_q[VALUE_BITS-2:0]};
	assign re_sum = dre_neg_q ? ({re_q[VALUE_BITS-1], re_q} - {1'b0, qv})
		: ({re_q[VALUE_BITS-1], re_q} + {1'b0, qv});
	assign im_sum = {im_q[VALUE_BITS-1], im_q} - {1'b0, qv};
	assign last_step = (k_q + CW'(1)) == cnt_eff;
	assign out_load  = (state_q == lfsc_pkg::ST_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfsc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lfsc_pkg::ST_IDLE: begin
				if (in_xfer && req_type == lfsc_pkg::REQ_QUERY) state_d = lfsc_pkg::ST_READ;
			end
			lfsc_pkg::ST_READ:  state_d = lfsc_pkg::ST_CHECK;
			lfsc_pkg::ST_CHECK: state_d = chk_exit ? lfsc_pkg::ST_DONE : lfsc_pkg::ST_MUL;
			lfsc_pkg::ST_MUL:   state_d = lfsc_pkg::ST_ACC;
			lfsc_pkg::ST_ACC: begin
				if (mstep_q == lfsc_pkg::MS_SQ_LAST) begin
					state_d = lfsc_pkg::ST_DEN;
				end else if (mstep_q == lfsc_pkg::MS_RE_LAST || mstep_q == lfsc_pkg::MS_IM_LAST) begin
					state_d = lfsc_pkg::ST_DIVLD;
				end else begin
					state_d = lfsc_pkg::ST_MUL;
				end
			end
			lfsc_pkg::ST_DEN:   state_d = lfsc_pkg::ST_MUL;
			lfsc_pkg::ST_DIVLD: state_d = lfsc_pkg::ST_DIV;
			lfsc_pkg::ST_DIV: begin
				if (dcnt_q == DCW'(lfsc_pkg::NUM_W - 1)) state_d = lfsc_pkg::ST_UPDATE;
			end
			lfsc_pkg::ST_UPDATE: begin
				if (mstep_q == lfsc_pkg::MS_RE_DONE) begin
					state_d = lfsc_pkg::ST_MUL;
				end else begin
					state_d = last_step ? lfsc_pkg::ST_DONE : lfsc_pkg::ST_READ;
				end
			end
			lfsc_pkg::ST_DONE: begin
				if (out_load) state_d = lfsc_pkg::ST_IDLE;
			end
			default: state_d = lfsc_pkg::ST_IDLE;
		endcase
	end

	// Flow datapath: payload registers, no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			lfsc_pkg::ST_IDLE: begin
				re_q <= point_re;
				im_q <= point_im;
				k_q  <= '0;
			end
			lfsc_pkg::ST_CHECK: begin
				res_q     <= chk_side;
				w_q       <= w_rd;
				are_q     <= are_d;
				aim_q     <= im_q;
				dre_neg_q <= dre[VALUE_BITS-1];
				mstep_q   <= lfsc_pkg::MS_SQ_FIRST;
				acc_q     <= '0;
			end
			lfsc_pkg::ST_MUL: begin
				prod_q <= mul_a * mul_b;
				sh_q   <= mul_sh;
			end
			lfsc_pkg::ST_ACC: begin
				acc_q   <= acc_q + (lfsc_pkg::ACC_W'(prod_q) << {sh_q, 5'd0});
				mstep_q <= mstep_q + 1'b1;
			end
			lfsc_pkg::ST_DEN: begin
				if (|acc_q[127:96]) begin
					den_q <= '1;
				end else if (acc_q[95:32] == '0) begin
					den_q <= lfsc_pkg::DEN_W'(1);
				end else begin
					den_q <= acc_q[95:32];
				end
				acc_q   <= '0;
				mstep_q <= lfsc_pkg::MS_RE_FIRST;
			end
			lfsc_pkg::ST_DIVLD: begin
				num_q  <= lfsc_pkg::NUM_W'(acc_q) << 1;
				rem_q  <= '0;
				quo_q  <= '0;
				dcnt_q <= '0;
				acc_q  <= '0;
			end
			lfsc_pkg::ST_DIV: begin
				rem_q  <= div_ge ? lfsc_pkg::DEN_W'(div_r2 - {1'b0, den_q})
					: div_r2[lfsc_pkg::DEN_W-1:0];
				quo_q  <= {quo_q[lfsc_pkg::NUM_W-2:0], div_ge};
				num_q  <= num_q << 1;
				dcnt_q <= dcnt_q + 1'b1;
			end
			lfsc_pkg::ST_UPDATE: begin
				if (mstep_q == lfsc_pkg::MS_RE_DONE) begin
					re_q <= sat_fit(re_sum);
				end else begin
					im_q  <= sat_fit(im_sum);
					k_q   <= k_q + CW'(1);
					res_q <= (re_q < w_q) ? lfsc_pkg::SIDE_LEFT : lfsc_pkg::SIDE_RIGHT;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) side_q <= res_q;
	end

	`LFSC_ASSERT_NXT(a_query_starts, in_xfer && req_type == lfsc_pkg::REQ_QUERY,
		state_q == lfsc_pkg::ST_READ, "query transfer did not start a table read")
	`LFSC_ASSERT_IMP(a_busy_stalls, state_q != lfsc_pkg::ST_IDLE, in_stall,
		"input taken while a query runs")
	`LFSC_ASSERT_IMP(a_check_after_read, state_q == lfsc_pkg::ST_CHECK,
		$past(state_q) == lfsc_pkg::ST_READ, "check without a table read before it")
	`LFSC_ASSERT_IMP(a_den_nonzero, state_q == lfsc_pkg::ST_DIV, den_q != '0,
		"divider running with a zero denominator")
	`LFSC_ASSERT_IMP(a_step_in_range, state_q == lfsc_pkg::ST_READ, k_q < cnt_eff,
		"flow step beyond the sample count")
endmodule

>>> dv/lfsc_checker.sv
// Side-prediction scoreboard for the Loewner flow side classifier.
module lfsc_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic                                req_type,
	input  logic [lfsc_pkg::SAMPLE_INDEX_W-1:0] sample_index,
	input  logic signed [47:0]                  drive_value,
	input  logic signed [47:0]                  point_re,
	input  logic signed [47:0]                  point_im,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic                                side,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [lfsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lfsc_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                  errors,
	output int                                  pending
);
	localparam logic signed [63:0] VMAX = 64'sd140737488355327;
	localparam logic signed [63:0] VMIN = -64'sd140737488355328;

	logic signed [63:0] drive_tab [int];
	logic signed [63:0] smin_tab [int];
	logic signed [63:0] smax_tab [int];
	logic signed [63:0] run_min, run_max;
	logic [lfsc_pkg::COUNT_W-1:0] count_reg;
	logic [lfsc_pkg::STEP_W-1:0]  step_reg;
	logic               side_fifo [256];
	int                 side_wr, side_rd;

	function automatic logic signed [63:0] clamp48(logic signed [63:0] x);
		if (x > VMAX) return VMAX;
		if (x < VMIN) return VMIN;
		return x;
	endfunction

	function automatic int steps_in_use();
		if (count_reg == 0) return 1;
		if (count_reg > lfsc_pkg::MAX_SAMPLES_DEF) return lfsc_pkg::MAX_SAMPLES_DEF;
		return int'(count_reg);
	endfunction

	// Saturated quotient 2*dt*m / den.
	function automatic logic signed [63:0] flow_quot(logic [63:0] m, logic [63:0] den);
		logic [127:0] num, q;
		num = ({96'd0, step_reg} * {64'd0, m}) << 1;
		q = num / {64'd0, den};
		if (q > 128'(VMAX)) q = 128'(VMAX);
		return $signed(q[63:0]);
	endfunction

	function automatic void flow_advance(inout logic signed [63:0] re, im,
			input logic signed [63:0] w);
		logic signed [63:0] dre;
		logic [63:0]  are, aim, den;
		logic [127:0] sq;
		dre = clamp48(re - w);
		are = (dre < 0) ? -dre : dre;
		aim = (im < 0) ? -im : im;
		sq = {64'd0, are} * {64'd0, are} + {64'd0, aim} * {64'd0, aim};
		den = (sq[127:96] != 0) ? '1 : sq[95:32];
		if (den == 0) den = 1;
		re = clamp48(re + ((dre < 0) ? -flow_quot(are, den) : flow_quot(are, den)));
		im = clamp48(im + ((im < 0) ? flow_quot(aim, den) : -flow_quot(aim, den)));
	endfunction

	function automatic logic predict_side(logic signed [63:0] re, logic signed [63:0] im);
		int n;
		n = steps_in_use();
		for (int k = 0; k < n; k++) begin
			if (im <= 0)
				return (re < drive_tab[k]) ? lfsc_pkg::SIDE_LEFT : lfsc_pkg::SIDE_RIGHT;
			if (re < smin_tab[k]) return lfsc_pkg::SIDE_LEFT;
			if (re > smax_tab[k]) return lfsc_pkg::SIDE_RIGHT;
			flow_advance(re, im, drive_tab[k]);
		end
		return (re < drive_tab[n-1]) ? lfsc_pkg::SIDE_LEFT : lfsc_pkg::SIDE_RIGHT;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [63:0] v;
		logic exp_side;
		int idx;
		if (!arst_n) begin
			run_min    = 0;
			run_max    = 0;
			side_wr    = 0;
			side_rd    = 0;
			count_reg <= lfsc_pkg::SAMPLE_COUNT_RST;
			step_reg  <= lfsc_pkg::STEP_SIZE_RST;
			errors    <= 0;
			pending   <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == lfsc_pkg::CFG_SAMPLE_COUNT)
					count_reg <= cfg_data[lfsc_pkg::COUNT_W-1:0];
				else if (cfg_index == lfsc_pkg::CFG_STEP_SIZE)
					step_reg <= cfg_data[lfsc_pkg::STEP_W-1:0];
			end
			if (in_valid && !in_stall) begin
				if (req_type == lfsc_pkg::REQ_LOAD) begin
					v = drive_value;
					idx = int'(sample_index);
					if (idx >= steps_in_use() - 1) begin
						run_min = v;
						run_max = v;
					end else begin
						if (v < run_min) run_min = v;
						if (v > run_max) run_max = v;
					end
					drive_tab[idx] = v;
					smin_tab[idx] = run_min;
					smax_tab[idx] = run_max;
				end else begin
					side_fifo[side_wr[7:0]] = predict_side(point_re, point_im);
					side_wr = side_wr + 1;
				end
			end
			if (out_valid && !out_stall) begin
				if (side_wr == side_rd) begin
					if (errors < 10) $display("side transfer %0b with nothing awaited", side);
					errors <= errors + 1;
				end else begin
					exp_side = side_fifo[side_rd[7:0]];
					side_rd = side_rd + 1;
					if (side !== exp_side) begin
						if (errors < 10)
							$display("side mismatch: expected %0b got %0b", exp_side, side);
						errors <= errors + 1;
					end
				end
			end
			pending <= side_wr - side_rd;
		end
	end
endmodule

>>> dv/tb_top.sv
// Stimulus, watchdog and verdict for the Loewner flow side classifier.
module tb_top;
	localparam logic signed [47:0] VMAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] VMIN = 48'sh8000_0000_0000;
	localparam logic signed [47:0] ONE  = 48'sh1_0000_0000;
	localparam int WATCHDOG_LIMIT = 60000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_stall;
	logic req_type = lfsc_pkg::REQ_LOAD;
	logic [lfsc_pkg::SAMPLE_INDEX_W-1:0] sample_index = '0;
	logic signed [47:0] drive_value = '0, point_re = '0, point_im = '0;
	logic out_valid, out_stall = 1'b0, side;
	logic cfg_valid = 1'b0, cfg_ready;
	logic [lfsc_pkg::CFG_IDX_W-1:0] cfg_index = lfsc_pkg::CFG_SAMPLE_COUNT;
	logic [lfsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	int errors, pending;
	int idle_pct = 0, stall_pct = 0, quiet = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	loewner_flow_side_classifier_core dut (.*);

	lfsc_checker chk (.*);

	always @(posedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

	// End the run if nothing transfers for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic signed [47:0] rand_value();
		logic signed [63:0] r;
		r = $signed({$urandom, $urandom});
		return 48'(r >>> $urandom_range(16, 40));
	endfunction

	task automatic send(logic rt, logic [lfsc_pkg::SAMPLE_INDEX_W-1:0] idx,
			logic signed [47:0] dv, logic signed [47:0] re, logic signed [47:0] im);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= rt;
		sample_index <= idx;
		drive_value  <= dv;
		point_re     <= re;
		point_im     <= im;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic load(int idx, logic signed [47:0] v);
		send(lfsc_pkg::REQ_LOAD, lfsc_pkg::SAMPLE_INDEX_W'(idx), v, rand_value(), rand_value());
	endtask

	task automatic query(logic signed [47:0] re, logic signed [47:0] im);
		send(lfsc_pkg::REQ_QUERY, lfsc_pkg::SAMPLE_INDEX_W'($urandom), rand_value(), re, im);
	endtask

	// Hold the sender until every side has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_reg(logic [lfsc_pkg::CFG_IDX_W-1:0] idx,
			logic [lfsc_pkg::CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int n;
		logic signed [47:0] im;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, saturation, both exits
		set_reg(lfsc_pkg::CFG_SAMPLE_COUNT, 4);
		set_reg(lfsc_pkg::CFG_STEP_SIZE, 32'hFFFF_FFFF);
		load(3, 0);
		load(2, VMAX);
		load(1, VMIN);
		load(0, ONE);
		query(0, 0);
		query(VMIN, VMIN);
		query(VMAX, 1);
		query(ONE >>> 1, ONE);
		query(0, VMAX);
		query(-(ONE <<< 1), ONE >>> 2);
		drain();
		set_reg(lfsc_pkg::CFG_SAMPLE_COUNT, 0);
		load(0, -(ONE * 5));
		query(-(ONE * 6), ONE);
		query(0, ONE);
		query(-(ONE * 5), 1);
		load(5, ONE);
		drain();
		set_reg(lfsc_pkg::CFG_SAMPLE_COUNT, 32'h0003_FFFF);
		load(131071, ONE * 3);
		load(0, -(ONE * 2));
		query(VMIN, ONE);
		query(VMAX, ONE);
		query(0, 0);
		drain();
		set_reg(lfsc_pkg::CFG_SAMPLE_COUNT, lfsc_pkg::MAX_SAMPLES_DEF);
		query(-(ONE * 2), -1);
		drain();

		// random: full descending loads, then queries
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 79; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 79; end
				default: begin idle_pct = 18; stall_pct = 18; end
			endcase
			n = $urandom_range(1, 6);
			set_reg(lfsc_pkg::CFG_SAMPLE_COUNT, n);
			case ($urandom_range(0, 3))
				0: set_reg(lfsc_pkg::CFG_STEP_SIZE, 1);
				1: set_reg(lfsc_pkg::CFG_STEP_SIZE, 32'hFFFF_FFFF);
				2: set_reg(lfsc_pkg::CFG_STEP_SIZE, $urandom_range(1, 1 << 20));
				default: set_reg(lfsc_pkg::CFG_STEP_SIZE, $urandom);
			endcase
			for (int i = n - 1; i >= 0; i--) load(i, rand_value());
			for (int q = 0; q < 6; q++) begin
				im = rand_value();
				if ($urandom_range(0, 9) < 8 && im < 0) im = -im;
				if (q == 3) drain();
				if ($urandom_range(0, 9) == 0)
					load($urandom_range(n - 1, 131071), rand_value());
				else if ($urandom_range(0, 9) == 0)
					load($urandom_range(0, n - 1), rand_value());
				query(rand_value(), im);
			end
			drain();
		end
		stall_pct = 0;
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
